>>> rtl/core/task_pick_srtf_or_priority_defines.svh
//------------------------------------------------------------------------------
// task_pick_srtf_or_priority_defines
// Assertion macros shared by the task pick block.
//------------------------------------------------------------------------------
`ifndef TASK_PICK_SRTF_OR_PRIORITY_DEFINES_SVH
`define TASK_PICK_SRTF_OR_PRIORITY_DEFINES_SVH

// same-cycle implication
`define TPSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tpsp_pkg.sv
//------------------------------------------------------------------------------
// tpsp_pkg
// Types and constants of the task pick block.
//------------------------------------------------------------------------------
package tpsp_pkg;

	localparam int IDX_W     = 6;
	localparam int KEY_W     = 16;
	localparam int LFSR_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam logic [1:0] ST_READY   = 2'd0;
	localparam logic [1:0] ST_RUNNING = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 1'b1;

	localparam logic MODE_SRTF     = 1'b0;
	localparam logic MODE_PRIORITY = 1'b1;

	localparam logic [LFSR_W-1:0] LFSR_POLY = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_INIT = 16'h0001;

	typedef struct packed {
		logic [1:0]  task_state;
		logic [3:0]  task_cpu;
		logic [15:0] arrival_time;
		logic [15:0] original_duration;
		logic [15:0] remaining_time;
		logic [7:0]  priority_req;
		logic [3:0]  requesting_cpu;
		logic        last_task;
	} task_in_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] chosen_index;
		logic             lottery_happened;
		logic [IDX_W-1:0] lottery_winner;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             runs_here;
		logic [15:0]      arrival;
		logic [15:0]      duration;
	} best_t;

	typedef struct packed {
		logic             take;
		logic             coin;
		logic             runs_here;
		logic [KEY_W-1:0] key;
	} pick_t;

endpackage

>>> rtl/core/tpsp_cmp.sv
//------------------------------------------------------------------------------
// tpsp_cmp
// Candidate check and compare of one task record against the kept best.
//------------------------------------------------------------------------------
module tpsp_cmp
	import tpsp_pkg::*;
(
	input  logic     policy_mode,
	input  logic     in_range,
	input  task_in_t item,
	input  logic     have_best,
	input  best_t    best,
	input  logic     coin_bit,
	output pick_t    pick
);

	logic             runs_here;
	logic             cand;
	logic [KEY_W-1:0] key;

	assign runs_here = (item.task_state == ST_RUNNING) && (item.task_cpu == item.requesting_cpu);
	assign cand      = in_range && ((item.task_state == ST_READY) || runs_here);
	assign key       = (policy_mode == MODE_PRIORITY) ? {8'd0, item.priority_req}
	                                                  : item.remaining_time;

	always_comb begin
		pick.take      = 1'b0;
		pick.coin      = 1'b0;
		pick.runs_here = runs_here;
		pick.key       = key;
		if (cand) begin
			if (!have_best) begin
				pick.take = 1'b1;
			end else if (key != best.key) begin
				pick.take = (policy_mode == MODE_PRIORITY) ? (key > best.key) : (key < best.key);
			end else if (best.runs_here) begin
				pick.take = 1'b0;
			end else if (runs_here) begin
				pick.take = 1'b1;
			end else if (item.arrival_time != best.arrival) begin
				pick.take = item.arrival_time < best.arrival;
			end else if (item.original_duration != best.duration) begin
				pick.take = item.original_duration < best.duration;
			end else begin
				pick.take = coin_bit;
				pick.coin = 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/tpsp_lfsr.sv
//------------------------------------------------------------------------------
// tpsp_lfsr
// Galois LFSR for tie-break coin flips, loadable from the seed register.
//------------------------------------------------------------------------------
module tpsp_lfsr
	import tpsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [LFSR_W-1:0] seed,
	input  logic              advance,
	output logic [LFSR_W-1:0] value
);

	logic [LFSR_W-1:0] lfsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_INIT;
		end else if (load) begin
			lfsr_q <= (seed == '0) ? LFSR_INIT : seed;
		end else if (advance) begin
			lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_POLY : '0);
		end
	end

	assign value = lfsr_q;

endmodule

>>> rtl/core/task_pick_srtf_or_priority.sv
// Result: the record marked last passes the input register, then the result register strobes result_valid.
// Throughput: one task record per cycle; busy is tied low, and a single
// compare stage lies between the input register and the kept-best registers.
// Configuration writes are always taken; cfg_ready is tied high.
// Reset: asynchronous; clears the scan, policy to shortest remaining time, LFSR to one.
//------------------------------------------------------------------------------
// task_pick_srtf_or_priority
// Picks the best task of a scan by remaining time or priority with tie-breaks.
//------------------------------------------------------------------------------
`include "task_pick_srtf_or_priority_defines.svh"

module task_pick_srtf_or_priority
	import tpsp_pkg::*;
#(
	parameter int MAX_TASKS = 64
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  task_in_t             task_item,
	output logic                 result_valid,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int              POS_W   = $clog2(MAX_TASKS + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TASKS);

	task_in_t          item_s1;
	logic              valid_s1;
	logic [POS_W-1:0]  pos_q;
	logic              have_best_q;
	best_t             best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              coin_used_q;
	logic [IDX_W-1:0]  coin_winner_q;
	logic              policy_q;
	result_t           result_q;
	logic              result_valid_q;

	logic              cfg_fire;
	logic              in_range;
	logic [IDX_W-1:0]  pos_idx;
	logic [LFSR_W-1:0] lfsr_value;
	pick_t             pick;
	logic              take;
	logic              coin;
	logic              found_nx;
	logic [IDX_W-1:0]  idx_nx;
	logic              coin_used_nx;
	logic [IDX_W-1:0]  coin_winner_nx;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_range  = pos_q < POS_MAX;
	assign pos_idx   = IDX_W'(pos_q);

	tpsp_cmp u_cmp (
		.policy_mode (policy_q),
		.in_range    (in_range),
		.item        (item_s1),
		.have_best   (have_best_q),
		.best        (best_q),
		.coin_bit    (lfsr_value[0]),
		.pick        (pick)
	);

	tpsp_lfsr u_lfsr (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (cfg_fire && (cfg_index == REG_RANDOM_SEED)),
		.seed    (cfg_data),
		.advance (coin),
		.value   (lfsr_value)
	);

	assign take           = valid_s1 && pick.take;
	assign coin           = valid_s1 && pick.coin;
	assign found_nx       = have_best_q || take;
	assign idx_nx         = take ? pos_idx : best_idx_q;
	assign coin_used_nx   = coin_used_q || coin;
	assign coin_winner_nx = coin ? (pick.take ? pos_idx : best_idx_q) : coin_winner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= MODE_SRTF;
		end else if (cfg_fire && (cfg_index == REG_POLICY_MODE)) begin
			policy_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= task_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			have_best_q    <= 1'b0;
			best_q         <= '0;
			best_idx_q     <= '0;
			coin_used_q    <= 1'b0;
			coin_winner_q  <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1 && item_s1.last_task;
			coin_winner_q  <= coin_winner_nx;
			if (valid_s1) begin
				if (item_s1.last_task) begin
					pos_q       <= '0;
					have_best_q <= 1'b0;
					best_q      <= '0;
					best_idx_q  <= '0;
					coin_used_q <= 1'b0;
				end else begin
					if (in_range) begin
						pos_q <= pos_q + POS_W'(1);
					end
					have_best_q <= found_nx;
					best_idx_q  <= idx_nx;
					coin_used_q <= coin_used_nx;
					if (take) begin
						best_q.key       <= pick.key;
						best_q.runs_here <= pick.runs_here;
						best_q.arrival   <= item_s1.arrival_time;
						best_q.duration  <= item_s1.original_duration;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && item_s1.last_task) begin
			result_q.found            <= found_nx;
			result_q.chosen_index     <= found_nx ? idx_nx : '0;
			result_q.lottery_happened <= coin_used_nx;
			result_q.lottery_winner   <= coin_winner_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`TPSP_ASSERT_NOW(a_no_index_when_none, clk, arst_n, result_valid_q && !result_q.found, result_q.chosen_index == '0, "chosen index set without a found task")
	`TPSP_ASSERT_NOW(a_result_from_last, clk, arst_n, result_valid_q, $past(start && task_item.last_task, 2), "result without a last record two cycles before")
	`TPSP_ASSERT_NOW(a_scan_cleared, clk, arst_n, result_valid_q, (pos_q == '0) && !have_best_q && !coin_used_q, "scan state not cleared after result")
	`TPSP_ASSERT_NOW(a_coin_needs_best, clk, arst_n, coin, have_best_q, "coin flip without a kept best")
	`TPSP_ASSERT_NOW(a_pos_bounded, clk, arst_n, 1'b1, (pos_q <= POS_MAX) && (lfsr_value != '0), "scan position past limit or LFSR locked")

endmodule
